### hw/rtl/uart_rb_pkg.sv
// ---------------------------------------------------------------------------
// UART ring buffer package
// Shared widths, codes, control structs and the size clamp.
// ---------------------------------------------------------------------------
package uart_rb_pkg;

   localparam int RING_DEPTH = 64;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int SIZE_W     = 7;
   localparam int MODE_W     = 3;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;

   localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'((RING_DEPTH < 64) ? RING_DEPTH : 64);
   localparam logic [BYTE_W-1:0] FULL_COUNT = 8'hff;

   localparam logic REG_TX_SIZE = 1'b0;
   localparam logic REG_RX_SIZE = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE = 3'd0,
      MODE_READ  = 3'd1,
      MODE_LINE  = 3'd2,
      MODE_DONE  = 3'd3,
      MODE_QUERY = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_TX_FULL = 2'd1,
      STAT_RX_EMPTY = 2'd2,
      STAT_RX_DROP = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic              clear;
      logic [BYTE_W-1:0] wdata;
      logic [SIZE_W-1:0] size;
   } ring_ctrl_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic [BYTE_W-1:0] rdata;
      logic [PTR_W-1:0]  head;
      logic [PTR_W-1:0]  tail;
      logic [SIZE_W-1:0] size;
   } ring_stat_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v < SIZE_MIN) begin
         r = SIZE_MIN;
      end else if (v > SIZE_CAP) begin
         r = SIZE_CAP;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### hw/rtl/uart_rb_if.sv
// ---------------------------------------------------------------------------
// UART ring buffer channels
// Valid/ready request and response channel interfaces.
// ---------------------------------------------------------------------------
interface uart_rb_req_if import uart_rb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] host_byte;
   logic [BYTE_W-1:0] line_byte;

   modport source (output valid, output mode, output host_byte, output line_byte,
                   input ready);
   modport sink (input valid, input mode, input host_byte, input line_byte,
                 output ready);
endinterface

interface uart_rb_rsp_if import uart_rb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                tx_start;
   logic [BYTE_W-1:0]   tx_byte;
   logic [BYTE_W-1:0]   read_byte;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   rx_count;
   logic                rx_enabled;

   modport source (output valid, output tx_start, output tx_byte, output read_byte,
                   output status, output rx_count, output rx_enabled, input ready);
   modport sink (input valid, input tx_start, input tx_byte, input read_byte,
                 input status, input rx_count, input rx_enabled, output ready);
endinterface

### hw/rtl/uart_rb_ring.sv
// ---------------------------------------------------------------------------
// UART ring buffer store
// One ring FIFO: synchronous memory, head/tail pointers, flags and size.
// ---------------------------------------------------------------------------
module uart_rb_ring import uart_rb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ring_ctrl_type ctrl,
   output ring_stat_type stat
);

   logic [BYTE_W-1:0] mem [RING_DEPTH];
   logic [BYTE_W-1:0] rd_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic              empty_ff, empty_in;
   logic              full_ff, full_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [PTR_W-1:0]  head_nx, tail_nx;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [SIZE_W-1:0] sz);
      logic [PTR_W:0] n;
      n = {1'b0, p} + {{PTR_W{1'b0}}, 1'b1};
      return (n >= sz) ? '0 : n[PTR_W-1:0];
   endfunction

   assign head_nx = advance(head_ff, size_ff);
   assign tail_nx = advance(tail_ff, size_ff);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      full_in  = full_ff;
      size_in  = size_ff;
      if (ctrl.clear) begin
         head_in  = '0;
         tail_in  = '0;
         empty_in = 1'b1;
         full_in  = 1'b0;
         size_in  = clamp_size(ctrl.size);
      end else if (ctrl.push) begin
         tail_in  = tail_nx;
         empty_in = 1'b0;
         full_in  = (tail_nx == head_ff);
      end else if (ctrl.pop) begin
         head_in  = head_nx;
         full_in  = 1'b0;
         empty_in = (head_nx == tail_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         full_ff  <= 1'b0;
         size_ff  <= SIZE_CAP;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         full_ff  <= full_in;
         size_ff  <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.clear) begin
         mem[tail_ff] <= ctrl.wdata;
      end
      rd_ff <= mem[head_ff];
   end

   assign stat.empty = empty_ff;
   assign stat.full  = full_ff;
   assign stat.rdata = rd_ff;
   assign stat.head  = head_ff;
   assign stat.tail  = tail_ff;
   assign stat.size  = size_ff;

endmodule

### hw/rtl/uart_tx_rx_ring_buffers_core.sv
// ---------------------------------------------------------------------------
// UART transmit/receive ring buffers
// Host/line event processor over two ring FIFOs with an APB size port.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one event per transaction (mode, host_byte, line_byte):
//   host write, host read, line byte received, transmit done or query.
//   rsp_ch returns exactly one result per event: tx_start/tx_byte for the
//   transmitter, read_byte and status for the host, plus rx_count and
//   rx_enabled after the event.
//   An event is accepted in the idle state, which presents the ring head to
//   the synchronous memory read; the execute state updates the ring and
//   loads the result register. A new event is accepted only once the
//   previous one has executed.
//   If rsp_ch stalls, the next event is still accepted and waits in the
//   execute stage until the result register is taken.
//   APB: 0x0 tx_size, 0x4 rx_size; a write clamps to 2..64 and empties
//   that ring (rx write also re-enables the receiver).
//   Reset empties both rings, sets both sizes to 64, receiver enabled,
//   transmitter idle. No clearing pass is needed.
// ---------------------------------------------------------------------------
module uart_tx_rx_ring_buffers_core import uart_rb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   uart_rb_req_if.sink       req_ch,
   uart_rb_rsp_if.source     rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   state_type state_ff, state_in;

   logic [MODE_W-1:0]   mode_ff;
   logic [BYTE_W-1:0]   host_byte_ff;
   logic [BYTE_W-1:0]   line_byte_ff;
   logic                tx_busy_ff, tx_busy_in;
   logic                rx_on_ff, rx_on_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                tx_start_ff, tx_start_in;
   logic [BYTE_W-1:0]   tx_byte_ff, tx_byte_in;
   logic [BYTE_W-1:0]   read_byte_ff, read_byte_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                req_fire, cfg_fire, out_free, exec_fire;
   ring_ctrl_type       tx_ctrl, rx_ctrl;
   ring_stat_type       tx_stat, rx_stat;
   logic [SIZE_W-1:0]   rx_diff, rx_fill;
   logic [BYTE_W-1:0]   rx_count;

   assign pready   = 1'b1;
   assign cfg_fire = psel && penable && pwrite && pready;
   assign prdata   = (paddr[2] == REG_RX_SIZE) ? DATA_W'(rx_stat.size)
                                               : DATA_W'(tx_stat.size);

   uart_rb_ring u_tx_ring (.clock(clock), .reset(reset), .ctrl(tx_ctrl), .stat(tx_stat));
   uart_rb_ring u_rx_ring (.clock(clock), .reset(reset), .ctrl(rx_ctrl), .stat(rx_stat));

   // control
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      exec_fire    = 1'b0;
      case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_EXEC: exec_fire = out_free;
         default: begin
            req_ch.ready = 1'b0;
            exec_fire    = 1'b0;
         end
      endcase
   end

   // event execution
   always_comb begin
      tx_ctrl       = '0;
      rx_ctrl       = '0;
      tx_ctrl.wdata = host_byte_ff;
      rx_ctrl.wdata = line_byte_ff;
      tx_ctrl.size  = SIZE_W'(pwdata);
      rx_ctrl.size  = SIZE_W'(pwdata);
      tx_busy_in    = tx_busy_ff;
      rx_on_in      = rx_on_ff;
      tx_start_in   = 1'b0;
      tx_byte_in    = '0;
      read_byte_in  = '0;
      status_in     = STAT_OK;
      if (cfg_fire) begin
         if (paddr[2] == REG_TX_SIZE) begin
            tx_ctrl.clear = 1'b1;
         end else begin
            rx_ctrl.clear = 1'b1;
            rx_on_in      = 1'b1;
         end
      end
      if (exec_fire) begin
         case (mode_type'(mode_ff))
            MODE_WRITE: begin
               if (tx_stat.empty && !tx_busy_ff) begin
                  tx_start_in = 1'b1;
                  tx_byte_in  = host_byte_ff;
                  tx_busy_in  = 1'b1;
               end else if (tx_stat.full) begin
                  status_in = STAT_TX_FULL;
               end else begin
                  tx_ctrl.push = 1'b1;
               end
            end
            MODE_READ: begin
               rx_on_in = 1'b1;
               if (rx_stat.empty) begin
                  status_in = STAT_RX_EMPTY;
               end else begin
                  read_byte_in = rx_stat.rdata;
                  rx_ctrl.pop  = 1'b1;
               end
            end
            MODE_LINE: begin
               if (rx_stat.full || !rx_on_ff) begin
                  rx_on_in  = 1'b0;
                  status_in = STAT_RX_DROP;
               end else begin
                  rx_ctrl.push = 1'b1;
               end
            end
            MODE_DONE: begin
               if (tx_stat.empty) begin
                  tx_busy_in = 1'b0;
               end else begin
                  tx_start_in = 1'b1;
                  tx_byte_in  = tx_stat.rdata;
                  tx_ctrl.pop = 1'b1;
                  tx_busy_in  = 1'b1;
               end
            end
            default: status_in = STAT_OK;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tx_busy_ff   <= 1'b0;
         rx_on_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tx_busy_ff   <= tx_busy_in;
         rx_on_ff     <= rx_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff      <= req_ch.mode;
         host_byte_ff <= req_ch.host_byte;
         line_byte_ff <= req_ch.line_byte;
      end
      if (exec_fire) begin
         tx_start_ff  <= tx_start_in;
         tx_byte_ff   <= tx_byte_in;
         read_byte_ff <= read_byte_in;
         status_ff    <= status_in;
      end
   end

   // ring state changes only on an execute or an APB size write, so the count is read live
   assign rx_diff = {1'b0, rx_stat.tail} - {1'b0, rx_stat.head};
   assign rx_fill = (rx_stat.tail >= rx_stat.head) ? rx_diff : rx_diff + rx_stat.size;

   always_comb begin
      if (rx_stat.empty) begin
         rx_count = '0;
      end else if (rx_stat.full) begin
         rx_count = FULL_COUNT;
      end else begin
         rx_count = BYTE_W'(rx_fill);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.tx_start   = tx_start_ff;
   assign rsp_ch.tx_byte    = tx_byte_ff;
   assign rsp_ch.read_byte  = read_byte_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.rx_count   = rx_count;
   assign rsp_ch.rx_enabled = rx_on_ff;

   // checks
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("accepted transaction did not enter execute");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && tx_start_ff) |-> tx_busy_ff)
      else $error("transmit start reported while transmitter idle");

   a_drop_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == STAT_RX_DROP)) |-> !rx_on_ff)
      else $error("dropped byte left receiver enabled");

   a_tx_flags: assert property (@(posedge clock) disable iff (reset)
      !(tx_stat.empty && tx_stat.full) && !(rx_stat.empty && rx_stat.full))
      else $error("ring flagged empty and full at once");

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// UART ring buffer core testbench
// Drives host, line and transmit-done events through the request channel,
// predicts every response with a local model of both rings and compares
// it field by field. Ring sizes are changed over APB between phases, and
// both channels are throttled at random.
// ---------------------------------------------------------------------------
module tb_top import uart_rb_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] host_byte;
      logic [BYTE_W-1:0] line_byte;
   } uart_event_type;

   typedef struct {
      logic                tx_start;
      logic [BYTE_W-1:0]   tx_byte;
      logic [BYTE_W-1:0]   read_byte;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   rx_count;
      logic                rx_enabled;
   } uart_result_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   uart_rb_req_if req_ch ();
   uart_rb_rsp_if rsp_ch ();

   uart_tx_rx_ring_buffers_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // ring model state
   logic [BYTE_W-1:0] txq_mem [RING_DEPTH];
   logic [BYTE_W-1:0] rxq_mem [RING_DEPTH];
   logic [PTR_W-1:0]  txq_rd, txq_wr, rxq_rd, rxq_wr;
   logic              txq_empty, txq_full, tx_active;
   logic              rxq_empty, rxq_full, rx_listen;
   logic [SIZE_W-1:0] txq_size, rxq_size;

   uart_event_type  pending_events [$];
   uart_result_type expected_results [$];

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   events_taken = 0;
   int   errors = 0;
   logic req_taken = 1'b0;
   logic rsp_hold = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [SIZE_W-1:0] size_limit(input logic [SIZE_W-1:0] v);
      if (v < SIZE_MIN) begin
         return SIZE_MIN;
      end
      if (v > SIZE_CAP) begin
         return SIZE_CAP;
      end
      return v;
   endfunction

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
                                                  input logic [SIZE_W-1:0] size);
      int n;
      n = int'(p) + 1;
      return (n >= int'(size)) ? '0 : PTR_W'(n);
   endfunction

   task automatic flush_tx_ring();
      txq_rd    = '0;
      txq_wr    = '0;
      txq_empty = 1'b1;
      txq_full  = 1'b0;
   endtask

   task automatic flush_rx_ring();
      rxq_rd    = '0;
      rxq_wr    = '0;
      rxq_empty = 1'b1;
      rxq_full  = 1'b0;
      rx_listen = 1'b1;
   endtask

   task automatic apply_event(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] hb,
                              input logic [BYTE_W-1:0] lb, output uart_result_type r);
      r = '{1'b0, '0, '0, STAT_OK, '0, 1'b0};
      case (mode)
         MODE_WRITE: begin
            if (txq_empty && !tx_active) begin
               r.tx_start = 1'b1;
               r.tx_byte  = hb;
               tx_active  = 1'b1;
            end else if (txq_full) begin
               r.status = STAT_TX_FULL;
            end else begin
               txq_mem[txq_wr] = hb;
               txq_wr    = ring_next(txq_wr, txq_size);
               txq_empty = 1'b0;
               txq_full  = (txq_wr == txq_rd);
            end
         end
         MODE_READ: begin
            rx_listen = 1'b1;
            if (rxq_empty) begin
               r.status = STAT_RX_EMPTY;
            end else begin
               r.read_byte = rxq_mem[rxq_rd];
               rxq_rd    = ring_next(rxq_rd, rxq_size);
               rxq_full  = 1'b0;
               rxq_empty = (rxq_rd == rxq_wr);
            end
         end
         MODE_LINE: begin
            if (rxq_full || !rx_listen) begin
               rx_listen = 1'b0;
               r.status  = STAT_RX_DROP;
            end else begin
               rxq_mem[rxq_wr] = lb;
               rxq_wr    = ring_next(rxq_wr, rxq_size);
               rxq_empty = 1'b0;
               rxq_full  = (rxq_wr == rxq_rd);
            end
         end
         MODE_DONE: begin
            if (txq_empty) begin
               tx_active = 1'b0;
            end else begin
               r.tx_start = 1'b1;
               r.tx_byte  = txq_mem[txq_rd];
               txq_rd    = ring_next(txq_rd, txq_size);
               txq_full  = 1'b0;
               txq_empty = (txq_rd == txq_wr);
               tx_active = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (rxq_empty) begin
         r.rx_count = '0;
      end else if (rxq_full) begin
         r.rx_count = FULL_COUNT;
      end else begin
         r.rx_count = BYTE_W'((int'(rxq_wr) + int'(rxq_size) - int'(rxq_rd)) % int'(rxq_size));
      end
      r.rx_enabled = rx_listen;
   endtask

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // request driver: new transaction only once the previous one was taken
   always @(negedge clock) begin : event_driver
      uart_event_type ev;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            ev = pending_events.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.mode      <= ev.mode;
            req_ch.host_byte <= ev.host_byte;
            req_ch.line_byte <= ev.line_byte;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : response_sink
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // long response stall so the core backs up and drops req ready
   initial begin
      wait (events_taken >= 150);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (250) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin : result_checker
      uart_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            apply_event(req_ch.mode, req_ch.host_byte, req_ch.line_byte, want);
            expected_results.push_back(want);
            events_taken++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual tx_byte %0h",
                        $time, rsp_ch.tx_byte);
               errors++;
            end else begin
               want = expected_results.pop_front();
               check_field("tx_start", want.tx_start, rsp_ch.tx_start);
               check_field("tx_byte", want.tx_byte, rsp_ch.tx_byte);
               check_field("read_byte", want.read_byte, rsp_ch.read_byte);
               check_field("status", want.status, rsp_ch.status);
               check_field("rx_count", want.rx_count, rsp_ch.rx_count);
               check_field("rx_enabled", want.rx_enabled, rsp_ch.rx_enabled);
            end
         end
      end
   end

   task automatic add_event(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] hb,
                            input logic [BYTE_W-1:0] lb);
      uart_event_type ev;
      ev.mode      = mode;
      ev.host_byte = hb;
      ev.line_byte = lb;
      pending_events.push_back(ev);
   endtask

   task automatic csr_write(input logic idx, input logic [SIZE_W-1:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= DATA_W'(val);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_TX_SIZE) begin
         txq_size = size_limit(val);
         flush_tx_ring();
      end else begin
         rxq_size = size_limit(val);
         flush_rx_ring();
      end
   endtask

   task automatic wait_idle();
      while (pending_events.size() > 0 || req_ch.valid || expected_results.size() > 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // bursts dominated by one event kind so the rings fill and drain
   task automatic add_random_events(input int count);
      mode_type          focus_modes [4] = '{MODE_LINE, MODE_READ, MODE_WRITE, MODE_DONE};
      int                left;
      int                run;
      mode_type          focus;
      logic [MODE_W-1:0] m;
      left = count;
      while (left > 0) begin
         run   = $urandom_range(4, 30);
         focus = focus_modes[$urandom_range(0, 3)];
         for (int i = 0; i < run && left > 0; i++) begin
            if ($urandom_range(0, 99) < 70) begin
               m = focus;
            end else begin
               m = MODE_W'($urandom_range(0, 7));
            end
            add_event(m, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
            left--;
         end
      end
   endtask

   task automatic run_phase(input logic [SIZE_W-1:0] tx_sz, input logic [SIZE_W-1:0] rx_sz,
                            input int count);
      csr_write(REG_TX_SIZE, tx_sz);
      csr_write(REG_RX_SIZE, rx_sz);
      add_random_events(count);
      wait_idle();
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_ch.valid     = 1'b0;
      req_ch.mode      = MODE_QUERY;
      req_ch.host_byte = '0;
      req_ch.line_byte = '0;
      rsp_ch.ready     = 1'b0;
      txq_size  = SIZE_CAP;
      rxq_size  = SIZE_CAP;
      tx_active = 1'b0;
      flush_tx_ring();
      flush_rx_ring();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 18;
      recv_idle_pct = 56;

      // both rings at the two-entry minimum, sizes below range
      csr_write(REG_TX_SIZE, SIZE_W'(0));
      csr_write(REG_RX_SIZE, SIZE_W'(1));
      add_event(MODE_QUERY, 8'h00, 8'h00);
      add_event(MODE_READ, 8'h00, 8'h00);
      add_event(MODE_DONE, 8'h00, 8'h00);
      add_event(MODE_WRITE, 8'h00, 8'hff);
      add_event(MODE_WRITE, 8'hff, 8'h00);
      add_event(MODE_WRITE, 8'h5a, 8'h00);
      add_event(MODE_WRITE, 8'h11, 8'h00);
      add_event(MODE_DONE, 8'h00, 8'h00);
      add_event(MODE_WRITE, 8'ha5, 8'h00);
      add_event(MODE_DONE, 8'h00, 8'h00);
      add_event(MODE_DONE, 8'h00, 8'h00);
      add_event(MODE_DONE, 8'h00, 8'h00);
      add_event(MODE_LINE, 8'hff, 8'h00);
      add_event(MODE_LINE, 8'h00, 8'hff);
      add_event(MODE_LINE, 8'h00, 8'h33);
      add_event(MODE_READ, 8'h00, 8'h00);
      add_event(MODE_LINE, 8'h00, 8'h44);
      add_event(MODE_READ, 8'h00, 8'h00);
      add_event(MODE_READ, 8'h00, 8'h00);
      add_event(MODE_READ, 8'h00, 8'h00);
      for (int m = int'(MODE_QUERY) + 1; m < (1 << MODE_W); m++) begin
         add_event(MODE_W'(m), 8'hff, 8'hff);
      end
      wait_idle();

      run_phase(SIZE_W'(64), SIZE_W'(64), 170);
      run_phase(SIZE_W'(127), SIZE_W'(3), 130);

      send_idle_pct = 56;
      recv_idle_pct = 18;
      run_phase(SIZE_W'(5), SIZE_W'(65), 130);
      run_phase(SIZE_W'(2), SIZE_W'(8), 130);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(SIZE_W'(3), SIZE_W'(2), 120);
      run_phase(SIZE_W'(100), SIZE_W'(127), 120);

      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results still outstanding", $time, expected_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
